// ----- hdl/rtn_pkg.sv -----
// Types, constants and helpers shared by the RGBA to NV21 converter.
`default_nettype none
package rtn_pkg;

  localparam int COUNT_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int ADDR_W   = 24;
  localparam int PROD_W   = COUNT_W + SIZE_W;
  localparam int SUM_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(1080);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  // queue depth, a power of two
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int C_Y_R = 66;
  localparam int C_Y_G = 129;
  localparam int C_Y_B = 25;
  localparam int C_U_R = 38;
  localparam int C_U_G = 74;
  localparam int C_U_B = 112;
  localparam int C_V_R = 112;
  localparam int C_V_G = 94;
  localparam int C_V_B = 18;
  localparam logic [SUM_W-1:0] ROUND_OFS  = SUM_W'(128);
  localparam logic [7:0]       CHROMA_OFS = 8'd128;
  localparam logic [7:0]       LUMA_OFS   = 8'd16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pixel_t;

  typedef struct packed {
    logic [7:0]        luma;
    logic [ADDR_W-1:0] luma_address;
    logic              chroma_valid;
    logic [7:0]        v_value;
    logic [7:0]        u_value;
    logic [ADDR_W-1:0] chroma_address;
    logic              frame_last;
  } out_pixel_t;

  typedef struct packed {
    in_pixel_t          pix;
    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;
    logic [SIZE_W-1:0]  width;
    logic               chroma_valid;
    logic               frame_last;
  } job_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/rtn_front.sv -----
// Front end: frame registers, position counters and the job queue.
`default_nettype none
module rtn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  rtn_pkg::in_pixel_t            in_data,
  input  logic                          cfg_we,
  input  logic [rtn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtn_pkg::SIZE_W-1:0]    cfg_data,
  output logic                          job_vld,
  output rtn_pkg::job_t                 job,
  input  logic                          job_rdy
);
  import rtn_pkg::*;

  logic [SIZE_W-1:0]  width_r, height_r;
  logic [COUNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  job_t               q_r [QDEPTH];
  logic [QPTR_W-1:0]  wptr_r, rptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  logic [SIZE_W-1:0]  w_eff, h_eff, col_inc, row_inc;
  logic               row_end, frame_end, accept, take;
  job_t               new_job;

  assign w_eff     = clamp_size(width_r, MAX_WIDTH);
  assign h_eff     = clamp_size(height_r, MAX_HEIGHT);
  assign col_inc   = {1'b0, col_r} + SIZE_W'(1);
  assign row_inc   = {1'b0, row_r} + SIZE_W'(1);
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_end && (row_inc >= h_eff);

  assign full    = cnt_r == QCNT_W'(QDEPTH);
  assign accept  = push && !full;
  assign job_vld = cnt_r != '0;
  assign take    = job_vld && job_rdy;
  assign job     = q_r[rptr_r];

  always_comb begin
    new_job.pix          = in_data;
    new_job.col          = col_r;
    new_job.row          = row_r;
    new_job.width        = w_eff;
    new_job.chroma_valid = !row_r[0] && !col_r[0];
    new_job.frame_last   = frame_end;
    col_nxt = row_end ? '0 : col_inc[COUNT_W-1:0];
    row_nxt = row_r;
    if (row_end) begin
      row_nxt = frame_end ? '0 : row_inc[COUNT_W-1:0];
    end
    cnt_nxt = cnt_r;
    if (accept && !take) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (take && !accept) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      col_r    <= '0;
      row_r    <= '0;
      wptr_r   <= '0;
      rptr_r   <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_WIDTH) width_r <= cfg_data;
      if (cfg_we && cfg_index == REG_FRAME_HEIGHT) height_r <= cfg_data;
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (take) rptr_r <= rptr_r + QPTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_r[wptr_r] <= new_job;
  end

endmodule
`default_nettype wire

// ----- hdl/rtn_back.sv -----
// Back end: color and address arithmetic and the result queue.
`default_nettype none
module rtn_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_vld,
  input  rtn_pkg::job_t       job,
  output logic                job_rdy,
  output logic                empty,
  output rtn_pkg::out_pixel_t out_data,
  input  logic                pop
);
  import rtn_pkg::*;

  logic                s1_vld_r;
  logic [SUM_W-1:0]    y_sum_r, v_sum_r, u_sum_r;
  logic [ADDR_W-1:0]   lprod_r, cprod_r;
  logic [COUNT_W-1:0]  s1_col_r;
  logic                s1_cv_r, s1_last_r;

  out_pixel_t          oq_r [QDEPTH];
  logic [QPTR_W-1:0]   oq_wptr_r, oq_rptr_r;
  logic [QCNT_W-1:0]   oq_cnt_r, oq_cnt_nxt;

  logic [PROD_W-1:0]   lprod, cprod;
  logic [SUM_W-1:0]    y_sum, v_sum, u_sum;
  logic                oq_room, s1_adv, take, oq_push, oq_pop;
  out_pixel_t          res;

  assign lprod = PROD_W'(job.row) * PROD_W'(job.width);
  assign cprod = PROD_W'(job.row[COUNT_W-1:1]) * PROD_W'(job.width);
  assign y_sum = SUM_W'(C_Y_R * job.pix.red) + SUM_W'(C_Y_G * job.pix.green)
               + SUM_W'(C_Y_B * job.pix.blue) + ROUND_OFS;
  assign v_sum = SUM_W'(C_V_R * job.pix.red) - SUM_W'(C_V_G * job.pix.green)
               - SUM_W'(C_V_B * job.pix.blue) + ROUND_OFS;
  assign u_sum = SUM_W'(C_U_B * job.pix.blue) - SUM_W'(C_U_R * job.pix.red)
               - SUM_W'(C_U_G * job.pix.green) + ROUND_OFS;

  assign oq_room = oq_cnt_r != QCNT_W'(QDEPTH);
  assign s1_adv  = !s1_vld_r || oq_room;
  assign job_rdy = s1_adv;
  assign take    = job_vld && s1_adv;
  assign oq_push = s1_vld_r && oq_room;
  assign empty   = oq_cnt_r == '0;
  assign oq_pop  = pop && !empty;
  assign out_data = oq_r[oq_rptr_r];

  always_comb begin
    res.luma           = y_sum_r[SUM_W-1:8] + LUMA_OFS;
    res.luma_address   = lprod_r + ADDR_W'(s1_col_r);
    res.chroma_valid   = s1_cv_r;
    res.v_value        = s1_cv_r ? v_sum_r[SUM_W-1:8] + CHROMA_OFS : '0;
    res.u_value        = s1_cv_r ? u_sum_r[SUM_W-1:8] + CHROMA_OFS : '0;
    res.chroma_address = s1_cv_r ? cprod_r + ADDR_W'(s1_col_r) : '0;
    res.frame_last     = s1_last_r;
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) oq_cnt_nxt = oq_cnt_r + QCNT_W'(1);
    else if (oq_pop && !oq_push) oq_cnt_nxt = oq_cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (s1_adv) s1_vld_r <= job_vld;
      if (oq_push) oq_wptr_r <= oq_wptr_r + QPTR_W'(1);
      if (oq_pop) oq_rptr_r <= oq_rptr_r + QPTR_W'(1);
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      y_sum_r   <= y_sum;
      v_sum_r   <= v_sum;
      u_sum_r   <= u_sum;
      lprod_r   <= lprod[ADDR_W-1:0];
      cprod_r   <= cprod[ADDR_W-1:0];
      s1_col_r  <= job.col;
      s1_cv_r   <= job.chroma_valid;
      s1_last_r <= job.frame_last;
    end
    if (oq_push) oq_r[oq_wptr_r] <= res;
  end

endmodule
`default_nettype wire

// ----- hdl/rgba_to_nv21_converter.sv -----
// Top level of the RGBA to NV21 pixel converter.
//
//   channel  direction  transfer when     payload
//   input    in         push && !full     in_data  (red, green, blue)
//   result   out        pop && !empty     out_data (luma, addresses, V/U, frame_last)
//   config   in         cfg_we            cfg_index, cfg_data
//
// One pixel per cycle while full is low and results are popped; a result is visible only
// after job queue write, arithmetic stage with address multipliers and result queue write.
// full rises while the four-entry job queue holds four jobs; the arithmetic stage holds
// while the four-entry result queue holds four results.
// Synchronous reset clears counters and queues and loads width 1920, height 1080.
`default_nettype none
module rgba_to_nv21_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  rtn_pkg::in_pixel_t            in_data,
  output logic                          empty,
  input  logic                          pop,
  output rtn_pkg::out_pixel_t           out_data,
  input  logic                          cfg_we,
  input  logic [rtn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rtn_pkg::SIZE_W-1:0]    cfg_data
);
  import rtn_pkg::*;

  logic job_vld, job_rdy;
  job_t job;

  rtn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .job_vld  (job_vld),
    .job      (job),
    .job_rdy  (job_rdy)
  );

  rtn_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job_vld (job_vld),
    .job     (job),
    .job_rdy (job_rdy),
    .empty   (empty),
    .out_data(out_data),
    .pop     (pop)
  );

endmodule
`default_nettype wire

// ----- hdl/rtn_checker.sv -----
// Port-level assertions for the converter and their bind to the top level.
`default_nettype none
module rtn_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input rtn_pkg::out_pixel_t out_data
);
  import rtn_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !out_data.chroma_valid |->
      out_data.v_value == '0 && out_data.u_value == '0 && out_data.chroma_address == '0)
    else $error("chroma fields set on a pixel without chroma");

  a_chroma_below_luma: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_data.chroma_valid |-> out_data.chroma_address <= out_data.luma_address)
    else $error("chroma address beyond luma address");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind rgba_to_nv21_converter rtn_checker u_chk (.*);
`default_nettype wire
